// ===== rtl/fts_pkg.sv =====
// Shared types, widths, register codes and reset values for the frame step timer.
package fts_pkg;

   // Field widths
   localparam int TIME_W   = 64;
   localparam int WORD_W   = 32;
   localparam int TARGET_W = 24;
   localparam int CSR_IDX_W = 2;

   // Defaults for the top-level parameters
   localparam int TICKS_PER_SEC_DEF = 10000000;
   localparam int MAX_STEPS_DEF     = 64;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTER_FREQUENCY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELTA_COUNTS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_STEP_MODE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_STEP_TICKS = 2'd3;

   // Register reset values
   localparam logic [WORD_W-1:0]   RST_COUNTER_FREQUENCY = 32'd10000000;
   localparam logic [WORD_W-1:0]   RST_MAX_DELTA_COUNTS  = 32'd1000000;
   localparam logic                RST_FIXED_STEP_MODE   = 1'b0;
   localparam logic [TARGET_W-1:0] RST_TARGET_STEP_TICKS = 24'd166666;

   // Request kinds
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_RESYNC = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_MUL,
      ST_DIV,
      ST_SNAP,
      ST_ACCUM,
      ST_LATCH,
      ST_MOD,
      ST_LOAD,
      ST_EMIT
   } fts_state_type;

endpackage

// ===== rtl/fts_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module fts_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic                       done,
   output logic [A_WIDTH+B_WIDTH-1:0] product
);

   localparam int P_WIDTH = A_WIDTH + B_WIDTH;
   localparam int CNT_W   = $clog2(A_WIDTH + 1);

   logic [A_WIDTH-1:0] mplier_ff, mplier_in;
   logic [P_WIDTH-1:0] mcand_ff, mcand_in;
   logic [P_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;

   always_comb begin
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         mplier_in = a;
         mcand_in  = P_WIDTH'(b);
         acc_in    = '0;
         cnt_in    = CNT_W'(A_WIDTH);
      end else if (cnt_ff != '0) begin
         // add the shifted multiplicand when the low multiplier bit is set
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mplier_in = mplier_ff >> 1;
         mcand_in  = mcand_ff << 1;
         cnt_in    = cnt_ff - CNT_W'(1);
      end
      done_in = !start && (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/fts_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, quotient and remainder.
module fts_div #(
   parameter int N_WIDTH = 64,
   parameter int D_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [N_WIDTH-1:0] dividend,
   input  logic [D_WIDTH-1:0] divisor,
   output logic               done,
   output logic [N_WIDTH-1:0] quotient,
   output logic [D_WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(N_WIDTH + 1);

   logic [N_WIDTH-1:0] quo_ff, quo_in;
   logic [D_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [D_WIDTH:0]   trial;
   logic [D_WIDTH:0]   trial_sub;
   logic               fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[N_WIDTH-1]};
      trial_sub = trial - {1'b0, divisor};
      fits      = trial >= {1'b0, divisor};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(N_WIDTH);
      end else if (cnt_ff != '0) begin
         // partial remainder stays below the divisor, so it fits D_WIDTH bits
         quo_in = {quo_ff[N_WIDTH-2:0], fits};
         rem_in = fits ? trial_sub[D_WIDTH-1:0] : trial[D_WIDTH-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
      end
      done_in = !start && (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/fixed_timestep_frame_timer.sv =====
// Frame step timer top level: handshakes, control sequencer and timekeeping state.
//
// A resync transaction returns nothing. A tick transaction runs through a bit-serial
// multiplier and a bit-serial divider to scale the clamped counter difference into
// canonical ticks, then through snap, accumulate and rate bookkeeping; when a full
// second of counts has gone by, the divider runs a second pass to reduce the second
// accumulator. Results then leave at one per cycle while rsp_stall is low: one per
// step (up to MAX_STEPS), or a single status result when no step is due.
// The next request is accepted once the last result of the current tick has been taken.
module fixed_timestep_frame_timer #(
   parameter int TICKS_PER_SEC = fts_pkg::TICKS_PER_SEC_DEF,
   parameter int MAX_STEPS     = fts_pkg::MAX_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [fts_pkg::TIME_W-1:0]    req_counter_now,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_step_taken,
   output logic [fts_pkg::TIME_W-1:0]    rsp_elapsed_ticks,
   output logic [fts_pkg::TIME_W-1:0]    rsp_total_ticks,
   output logic [fts_pkg::WORD_W-1:0]    rsp_frame_number,
   output logic [fts_pkg::WORD_W-1:0]    rsp_frames_per_second,
   output logic                          rsp_last_of_run,
   // configuration
   input  logic                          csr_write,
   input  logic [fts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fts_pkg::WORD_W-1:0]    csr_wdata
);

   import fts_pkg::*;

   localparam int TPS_W  = $clog2(TICKS_PER_SEC + 1);
   localparam int PROD_W = WORD_W + TPS_W;
   localparam int CNT_W  = $clog2(MAX_STEPS + 1);
   localparam logic [TIME_W-1:0] SNAP_WINDOW = TIME_W'(TICKS_PER_SEC / 4000);

   fts_state_type state_ff, state_in;

   // configuration
   logic [WORD_W-1:0]   freq_ff, freq_in;
   logic [WORD_W-1:0]   max_delta_ff, max_delta_in;
   logic                fixed_ff, fixed_in;
   logic [TARGET_W-1:0] target_ff, target_in;

   // timekeeping state
   logic [TIME_W-1:0] last_ff, last_in;
   logic [TIME_W-1:0] sec_ff, sec_in;
   logic [TIME_W-1:0] left_ff, left_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [TIME_W-1:0] total_ff, total_in;
   logic [WORD_W-1:0] frame_ff, frame_in;
   logic [WORD_W-1:0] fts_ff, fts_in;
   logic [WORD_W-1:0] fps_ff, fps_in;

   // per-tick working registers
   logic [TIME_W-1:0] raw_ff, raw_in;
   logic [TIME_W-1:0] scaled_ff, scaled_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic step_taken_ff, step_taken_in;
   logic last_run_ff, last_run_in;

   // sequencer outputs
   logic mul_start;
   logic div_start;
   logic div_mod_sel;
   logic load_any;
   logic load_next;

   logic req_accept;
   logic rsp_accept;

   // derived values
   logic [WORD_W-1:0]   freq_eff;
   logic [TARGET_W-1:0] target_eff;
   logic [TIME_W-1:0]   target64;
   logic [TIME_W-1:0]   two_target64;
   logic [WORD_W-1:0]   clamp_delta;
   logic [TIME_W-1:0]   snap_diff;
   logic [TIME_W:0]     left_sum;
   logic [TIME_W-1:0]   left_sat;
   logic                sec_ge;
   logic                has_step;
   logic                more_after;
   logic [CNT_W-1:0]    cnt_plus;
   logic [TIME_W-1:0]   step_val;
   logic [WORD_W-1:0]   fts_inc;

   // serial units
   logic                mul_done;
   logic [PROD_W-1:0]   mul_prod;
   logic                div_done;
   logic [TIME_W-1:0]   div_dividend;
   logic [TIME_W-1:0]   div_quo;
   logic [WORD_W-1:0]   div_rem;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   fts_mul #(
      .A_WIDTH (WORD_W),
      .B_WIDTH (TPS_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (clamp_delta),
      .b       (TPS_W'(TICKS_PER_SEC)),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign div_dividend = div_mod_sel ? sec_ff : TIME_W'(mul_prod);

   fts_div #(
      .N_WIDTH (TIME_W),
      .D_WIDTH (WORD_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (freq_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // derived values
   always_comb begin
      freq_eff     = (freq_ff == '0) ? WORD_W'(1) : freq_ff;
      target_eff   = (target_ff == '0) ? TARGET_W'(1) : target_ff;
      target64     = TIME_W'(target_eff);
      two_target64 = TIME_W'({target_eff, 1'b0});
      clamp_delta  = (raw_ff > TIME_W'(max_delta_ff)) ? max_delta_ff : raw_ff[WORD_W-1:0];
      snap_diff    = (scaled_ff >= target64) ? (scaled_ff - target64) : (target64 - scaled_ff);
      left_sum     = {1'b0, left_ff} + {1'b0, scaled_ff};
      left_sat     = left_sum[TIME_W] ? '1 : left_sum[TIME_W-1:0];
      sec_ge       = sec_ff >= TIME_W'(freq_eff);
      has_step     = !fixed_ff || (left_ff >= target64);
      cnt_plus     = cnt_ff + CNT_W'(1);
      // another step follows only if the cap allows and two targets remain
      more_after   = fixed_ff && (cnt_plus < CNT_W'(MAX_STEPS)) && (left_ff >= two_target64);
      step_val     = fixed_ff ? target64 : scaled_ff;
      fts_inc      = fts_ff + WORD_W'(has_step);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_type == REQ_TICK)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SNAP;
            end
         end
         ST_SNAP:  state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_LATCH;
         ST_LATCH: state_in = sec_ge ? ST_MOD : ST_LOAD;
         ST_MOD: begin
            if (div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_accept && last_run_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      mul_start   = (state_ff == ST_CLAMP);
      div_mod_sel = (state_ff == ST_LATCH);
      div_start   = ((state_ff == ST_MUL) && mul_done) || ((state_ff == ST_LATCH) && sec_ge);
      load_next   = (state_ff == ST_EMIT) && rsp_accept && !last_run_ff;
      load_any    = (state_ff == ST_LOAD) || load_next;
   end

   // configuration writes
   always_comb begin
      freq_in      = freq_ff;
      max_delta_in = max_delta_ff;
      fixed_in     = fixed_ff;
      target_in    = target_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COUNTER_FREQUENCY: freq_in      = csr_wdata;
            CSR_MAX_DELTA_COUNTS:  max_delta_in = csr_wdata;
            CSR_FIXED_STEP_MODE:   fixed_in     = csr_wdata[0];
            CSR_TARGET_STEP_TICKS: target_in    = csr_wdata[TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath
   always_comb begin
      last_in       = last_ff;
      sec_in        = sec_ff;
      left_in       = left_ff;
      elapsed_in    = elapsed_ff;
      total_in      = total_ff;
      frame_in      = frame_ff;
      fts_in        = fts_ff;
      fps_in        = fps_ff;
      raw_in        = raw_ff;
      scaled_in     = scaled_ff;
      cnt_in        = cnt_ff;
      step_taken_in = step_taken_ff;
      last_run_in   = last_run_ff;

      if (req_accept) begin
         last_in = req_counter_now;
         if (req_type == REQ_RESYNC) begin
            left_in = '0;
            sec_in  = '0;
            fts_in  = '0;
            fps_in  = '0;
         end else begin
            raw_in = req_counter_now - last_ff;
         end
      end

      case (state_ff)
         ST_CLAMP: sec_in = sec_ff + raw_ff;
         ST_DIV: begin
            if (div_done) begin
               scaled_in = div_quo;
            end
         end
         ST_SNAP: begin
            if (fixed_ff && (snap_diff < SNAP_WINDOW)) begin
               scaled_in = target64;
            end
         end
         ST_ACCUM: left_in = fixed_ff ? left_sat : '0;
         ST_LATCH: begin
            cnt_in = '0;
            if (sec_ge) begin
               fps_in = fts_inc;
               fts_in = '0;
            end else begin
               fts_in = fts_inc;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               sec_in = TIME_W'(div_rem);
            end
         end
         default: ;
      endcase

      if (load_any) begin
         if (has_step) begin
            elapsed_in    = step_val;
            total_in      = total_ff + step_val;
            frame_in      = frame_ff + WORD_W'(1);
            cnt_in        = cnt_plus;
            step_taken_in = 1'b1;
            last_run_in   = !more_after;
            if (fixed_ff) begin
               left_in = left_ff - target64;
            end
         end else begin
            // status result: no step due on this tick
            step_taken_in = 1'b0;
            last_run_in   = 1'b1;
         end
      end

      if (load_any) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff        <= raw_in;
      scaled_ff     <= scaled_in;
      step_taken_ff <= step_taken_in;
      last_run_ff   <= last_run_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         freq_ff      <= RST_COUNTER_FREQUENCY;
         max_delta_ff <= RST_MAX_DELTA_COUNTS;
         fixed_ff     <= RST_FIXED_STEP_MODE;
         target_ff    <= RST_TARGET_STEP_TICKS;
         last_ff      <= '0;
         sec_ff       <= '0;
         left_ff      <= '0;
         elapsed_ff   <= '0;
         total_ff     <= '0;
         frame_ff     <= '0;
         fts_ff       <= '0;
         fps_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         max_delta_ff <= max_delta_in;
         fixed_ff     <= fixed_in;
         target_ff    <= target_in;
         last_ff      <= last_in;
         sec_ff       <= sec_in;
         left_ff      <= left_in;
         elapsed_ff   <= elapsed_in;
         total_ff     <= total_in;
         frame_ff     <= frame_in;
         fts_ff       <= fts_in;
         fps_ff       <= fps_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_step_taken        = step_taken_ff;
   assign rsp_elapsed_ticks     = elapsed_ff;
   assign rsp_total_ticks       = total_ff;
   assign rsp_frame_number      = frame_ff;
   assign rsp_frames_per_second = fps_ff;
   assign rsp_last_of_run       = last_run_ff;

   // a result is only ever offered from the emit state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT))
      else $error("result valid outside emit state");

   // a fixed-mode result that is not the last leaves at least one whole target behind
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_run_ff) |-> (fixed_ff && (left_ff >= target64)))
      else $error("more steps announced without a whole target left");

   // the final step of a fixed-mode run leaves less than a target, unless capped
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_run_ff && step_taken_ff && fixed_ff)
         |-> ((left_ff < target64) || (cnt_ff == CNT_W'(MAX_STEPS))))
      else $error("run ended with a whole target left and cap not reached");

   // the divider only finishes in the states that wait for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV) || (state_ff == ST_MOD)))
      else $error("divider finished outside a divide wait");

   // an accepted tick starts the multiplier on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_type == REQ_TICK)) |=> mul_start)
      else $error("tick did not start the scaling multiply");

endmodule
